// ===== src/mss_pkg.sv =====
// Package for the masked signature search block: field widths, register
// indexes, reset values and the configuration bundle used by the match logic.
// No dependencies.
`default_nettype none

package mss_pkg;

    localparam int PATTERN_REG_BYTES     = 16;
    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_ADDRESS_BITS      = 48;
    localparam int FIELD_ADDR_BITS       = 48;
    localparam int CFG_DATA_BITS         = 64;
    localparam int CFG_INDEX_BITS        = 3;
    localparam int CARE_BITS             = 16;
    localparam int LENGTH_BITS           = 5;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_CARE_MASK      = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_RANGE_BASE     = 3'd4
    } t_cfg_index;

    localparam logic [CARE_BITS-1:0]   CARE_RESET   = 16'hFFFF;
    localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 5'd16;

    typedef struct packed {
        logic [PATTERN_REG_BYTES-1:0][7:0] pattern;
        logic [CARE_BITS-1:0]              care;
    } t_match_cfg;

endpackage

`default_nettype wire

// ===== src/mss_in_if.sv =====
// Input channel of the masked signature search block: one scanned byte and
// its range marks per transfer. Depends on nothing.
`default_nettype none

interface mss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_range;
    logic       last_of_range;

    modport source (output valid, output data_byte, output first_of_range,
                    output last_of_range, input ready);
    modport sink   (input valid, input data_byte, input first_of_range,
                    input last_of_range, output ready);
endinterface

`default_nettype wire

// ===== src/mss_out_if.sv =====
// Result channel of the masked signature search block: found flag and match
// address per transfer. Depends on mss_pkg.
`default_nettype none

interface mss_out_if import mss_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [FIELD_ADDR_BITS-1:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

// ===== src/mss_match.sv =====
// Masked window compare: checks the newest window bytes against the pattern
// under the care mask. Depends on mss_pkg.
`default_nettype none

module mss_match import mss_pkg::*; #(
    parameter int WIN  = DEF_MAX_PATTERN_BYTES,
    parameter int LENW = $clog2(WIN + 1)
) (
    input  wire logic [7:0]      i_win [WIN],
    input  wire t_match_cfg      i_cfg,
    input  wire logic [LENW-1:0] i_len,
    output logic                 o_hit
);

    localparam int IDXW = (WIN > 1) ? $clog2(WIN) : 1;

    always_comb begin
        logic            care;
        logic [LENW-1:0] pos;
        o_hit = 1'b1;
        for (int k = 0; k < WIN; k++) begin
            care = (k == 0) || i_cfg.care[k];
            pos  = i_len - LENW'(1) - LENW'(k);
            if ((LENW'(k) < i_len) && care &&
                (i_win[pos[IDXW-1:0]] != i_cfg.pattern[k])) begin
                o_hit = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/masked_signature_search.sv =====
// Masked signature search, top level: byte window, range counters, config
// registers and result register. Depends on mss_pkg, mss_in_if, mss_out_if,
// mss_match.
//
// Usage:
//   i_in_ch carries one byte of the scanned range per transfer, with
//   first_of_range opening a new range and last_of_range closing it.
//   o_out_ch carries at most one result per range: found=1 with the address
//   of the first matching byte (range_base plus offset), or found=0 when the
//   range closes without a match. Bytes after the answer are dropped until
//   the next first_of_range.
//   One byte is taken every cycle while i_in_ch.ready is high. The window compare and the address add
//   sit between the state registers and the result register, so a result
//   appears on o_out_ch in the cycle after the byte that caused it.
//   The result register parts the two sides: while a result waits and the
//   receiver stalls, i_in_ch.ready is held low; a result transfer frees the
//   input in the same cycle, so a ready receiver never holds the input back.
//   Reset clears the window and counters, loads the register defaults
//   (care mask all set, length 16) and empties the result register.
//   Configuration writes are taken on any cycle with i_cfg_we high.
`default_nettype none

module masked_signature_search import mss_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
    parameter int ADDRESS_BITS      = DEF_ADDRESS_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    mss_in_if.sink                         i_in_ch,
    mss_out_if.source                      o_out_ch,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int WIN  = (MAX_PATTERN_BYTES < PATTERN_REG_BYTES) ?
                          MAX_PATTERN_BYTES : PATTERN_REG_BYTES;
    localparam int LENW = $clog2(WIN + 1);
    localparam int AB   = ADDRESS_BITS;

    logic [63:0]                r_pat_lo;
    logic [63:0]                r_pat_hi;
    logic [CARE_BITS-1:0]       r_care;
    logic [LENGTH_BITS-1:0]     r_len;
    logic [FIELD_ADDR_BITS-1:0] r_base;

    logic [7:0]    r_win [WIN];
    logic [7:0]    n_win [WIN];
    logic [7:0]    eff_win [WIN];
    logic [LENW-1:0] r_seen, n_seen, eff_seen;
    logic [AB-1:0] r_off, n_off, eff_off;
    logic          r_done, n_done, eff_done;

    logic                       r_out_valid, n_out_valid;
    logic                       r_found, n_found;
    logic [FIELD_ADDR_BITS-1:0] r_addr, n_addr;

    logic            in_xfer;
    logic            hit;
    logic            out_load;
    logic [LENW-1:0] eff_len;
    logic [AB-1:0]   base_ab;
    logic [AB-1:0]   addr_ab;
    logic [FIELD_ADDR_BITS-1:0] addr_field;
    t_match_cfg      match_cfg;

    assign i_in_ch.ready = !r_out_valid || o_out_ch.ready;
    assign in_xfer       = i_in_ch.valid && i_in_ch.ready;

    always_comb begin
        if (r_len == '0) begin
            eff_len = LENW'(1);
        end else if (r_len > LENGTH_BITS'(WIN)) begin
            eff_len = LENW'(WIN);
        end else begin
            eff_len = LENW'(r_len);
        end
    end

    assign match_cfg.pattern = {r_pat_hi, r_pat_lo};
    assign match_cfg.care    = r_care;

    generate
        if (AB >= FIELD_ADDR_BITS) begin : g_wide
            assign base_ab    = AB'(r_base);
            assign addr_field = addr_ab[FIELD_ADDR_BITS-1:0];
        end else begin : g_narrow
            assign base_ab    = r_base[AB-1:0];
            assign addr_field = FIELD_ADDR_BITS'(addr_ab);
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            eff_win[i] = i_in_ch.first_of_range ? 8'h00 : r_win[i];
        end
        eff_seen = i_in_ch.first_of_range ? '0 : r_seen;
        eff_off  = i_in_ch.first_of_range ? '0 : r_off;
        eff_done = i_in_ch.first_of_range ? 1'b0 : r_done;
    end

    always_comb begin
        n_win[0] = i_in_ch.data_byte;
        for (int i = 1; i < WIN; i++) begin
            n_win[i] = eff_win[i-1];
        end
    end

    mss_match #(
        .WIN  (WIN),
        .LENW (LENW)
    ) u_match (
        .i_win (n_win),
        .i_cfg (match_cfg),
        .i_len (eff_len),
        .o_hit (hit)
    );

    always_comb begin
        n_seen  = (eff_seen == LENW'(WIN)) ? eff_seen : eff_seen + LENW'(1);
        n_off   = eff_off + AB'(1);
        addr_ab = base_ab + eff_off - AB'(eff_len - LENW'(1));
    end

    always_comb begin
        out_load = 1'b0;
        n_found  = r_found;
        n_addr   = r_addr;
        n_done   = eff_done;
        if (in_xfer && !eff_done) begin
            if (hit && (n_seen >= eff_len)) begin
                out_load = 1'b1;
                n_found  = 1'b1;
                n_addr   = addr_field;
                n_done   = 1'b1;
            end else if (i_in_ch.last_of_range) begin
                out_load = 1'b1;
                n_found  = 1'b0;
                n_addr   = '0;
                n_done   = 1'b1;
            end
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= CARE_RESET;
            r_len    <= LENGTH_RESET;
            r_base   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:    r_pat_lo <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_hi <= i_cfg_data;
                CFG_CARE_MASK:      r_care   <= i_cfg_data[CARE_BITS-1:0];
                CFG_PATTERN_LENGTH: r_len    <= i_cfg_data[LENGTH_BITS-1:0];
                CFG_RANGE_BASE:     r_base   <= i_cfg_data[FIELD_ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN; i++) begin
                r_win[i] <= 8'h00;
            end
            r_seen      <= '0;
            r_off       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_xfer) begin
                r_done <= n_done;
                if (eff_done) begin
                    for (int i = 0; i < WIN; i++) begin
                        r_win[i] <= eff_win[i];
                    end
                    r_seen <= eff_seen;
                    r_off  <= eff_off;
                end else begin
                    for (int i = 0; i < WIN; i++) begin
                        r_win[i] <= n_win[i];
                    end
                    r_seen <= n_seen;
                    r_off  <= n_off;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_found <= n_found;
            r_addr  <= n_addr;
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.found         = r_found;
    assign o_out_ch.match_address = r_addr;

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && !o_out_ch.found |-> o_out_ch.match_address == '0)
        else $error("not-found result with non-zero address");

    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_done && r_out_valid)
        else $error("range not closed after result");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out_ch.ready |-> !i_in_ch.ready)
        else $error("input taken while result register blocked");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= LENW'(WIN))
        else $error("window fill count beyond depth");

endmodule

`default_nettype wire

// ===== tb/masked_signature_search_tb.sv =====
`timescale 1ns / 100ps
// Testbench for masked_signature_search: a directed table, then random ranges
// under random sender gaps and receiver stalls, each result checked against an
// in-bench model of the window search or a typed answer. Depends on mss_pkg,
// both channel interfaces and the block.

module masked_signature_search_tb;
    import mss_pkg::*;

    localparam int RANDOM_ITEMS     = 700;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic                       found;
        logic [FIELD_ADDR_BITS-1:0] address;
    } t_search_answer;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SCAN,
        ROW_SCAN_QUIET,
        ROW_SCAN_ANSWER
    } t_row_kind;

    typedef struct {
        t_row_kind      kind;
        t_cfg_index     idx;
        logic [63:0]    value;
        logic [7:0]     data;
        bit             first;
        bit             last;
        t_search_answer answer;
    } t_dir_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    mss_in_if  in_ch();
    mss_out_if out_ch();

    masked_signature_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [7:0]                 shadow_window [PATTERN_REG_BYTES];
    int unsigned                shadow_seen;
    logic [FIELD_ADDR_BITS-1:0] shadow_offset;
    bit                         shadow_closed;

    logic [63:0]                cur_pattern_low;
    logic [63:0]                cur_pattern_high;
    logic [CARE_BITS-1:0]       cur_care;
    logic [LENGTH_BITS-1:0]     cur_length;
    logic [FIELD_ADDR_BITS-1:0] cur_base;

    t_search_answer answers_due[$];
    t_search_answer oldest;
    int             mismatches;
    int             bytes_scanned;
    int             cycle_count;
    int             burst_left;
    bit             eager;
    bit             long_hold_req;

    function automatic int unsigned used_length();
        int unsigned n;
        n = cur_length;
        if (n == 0) n = 1;
        if (n > PATTERN_REG_BYTES) n = PATTERN_REG_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] pattern_at(input int unsigned k);
        logic [127:0] both;
        both = {cur_pattern_high, cur_pattern_low};
        return both[k*8 +: 8];
    endfunction

    function automatic void forget_range();
        for (int unsigned k = 0; k < PATTERN_REG_BYTES; k++) shadow_window[k] = '0;
        shadow_seen   = 0;
        shadow_offset = '0;
        shadow_closed = 1'b0;
    endfunction

    function automatic void scan_byte(input logic [7:0] value, input bit first,
                                      input bit last, output bit answers,
                                      output t_search_answer ans);
        int unsigned                len;
        int unsigned                k;
        logic [FIELD_ADDR_BITS-1:0] here;
        bit                         hit;
        answers = 1'b0;
        ans     = '0;
        len     = used_length();
        if (first) forget_range();
        if (shadow_closed) return;
        for (k = PATTERN_REG_BYTES - 1; k > 0; k--) shadow_window[k] = shadow_window[k-1];
        shadow_window[0] = value;
        if (shadow_seen < PATTERN_REG_BYTES) shadow_seen++;
        here          = shadow_offset;
        shadow_offset = shadow_offset + 1'b1;
        hit = (shadow_seen >= len);
        for (k = 0; k < len; k++)
            if ((k == 0 || cur_care[k]) && shadow_window[len-1-k] != pattern_at(k)) hit = 1'b0;
        if (hit) begin
            shadow_closed = 1'b1;
            answers       = 1'b1;
            ans.found     = 1'b1;
            ans.address   = cur_base + here - FIELD_ADDR_BITS'(len - 1);
        end else if (last) begin
            shadow_closed = 1'b1;
            answers       = 1'b1;
        end
    endfunction

    function automatic logic [63:0] pick_pattern();
        logic [63:0] p;
        case ($urandom_range(0, 5))
            0: p = '0;
            1: p = '1;
            2: for (int k = 0; k < 8; k++) p[k*8 +: 8] = 8'($urandom_range(0, 3));
            default: p = {$urandom, $urandom};
        endcase
        return p;
    endfunction

    function automatic t_dir_row cfg_row(input t_cfg_index idx, input logic [63:0] value);
        t_dir_row r;
        r = '{kind: ROW_CFG, idx: idx, value: value, data: '0, first: 0, last: 0, answer: '0};
        return r;
    endfunction

    function automatic t_dir_row scan_row(input t_row_kind kind, input logic [7:0] data,
                                          input bit first, input bit last,
                                          input t_search_answer answer = '0);
        t_dir_row r;
        r = '{kind: kind, idx: CFG_PATTERN_LOW, value: '0, data: data, first: first,
              last: last, answer: answer};
        return r;
    endfunction

    task automatic write_reg(input t_cfg_index idx, input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_PATTERN_LOW:    cur_pattern_low  = value;
            CFG_PATTERN_HIGH:   cur_pattern_high = value;
            CFG_CARE_MASK:      cur_care         = value[CARE_BITS-1:0];
            CFG_PATTERN_LENGTH: cur_length       = value[LENGTH_BITS-1:0];
            CFG_RANGE_BASE:     cur_base         = value[FIELD_ADDR_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        i_cfg_we    <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] value, input bit first, input bit last,
                             input t_row_kind kind, input t_search_answer typed);
        bit             answers;
        t_search_answer ans;
        i_cfg_we             <= 1'b0;
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= value;
        in_ch.first_of_range <= first;
        in_ch.last_of_range  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        scan_byte(value, first, last, answers, ans);
        bytes_scanned++;
        if (kind == ROW_SCAN_ANSWER) answers_due.push_back(typed);
        else if (kind == ROW_SCAN && answers) answers_due.push_back(ans);
        if (!eager) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_range(input bit short_range);
        logic [7:0]     bytes_q[$];
        int             n;
        int             at;
        int             pl;
        int             k;
        bit             narrow;
        bit             drop_last;
        t_search_answer none;
        none   = '0;
        narrow = $urandom_range(0, 1);
        if (short_range) n = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(20, 48);
        else n = $urandom_range(1, 20);
        for (k = 0; k < n; k++)
            bytes_q.push_back(narrow ? 8'($urandom_range(0, 3)) : 8'($urandom));
        pl = used_length();
        // plant the pattern, wildcard positions sometimes left random
        if (pl <= n && $urandom_range(0, 9) < 6) begin
            at = $urandom_range(0, n - pl);
            for (k = 0; k < pl; k++)
                if (k == 0 || cur_care[k] || $urandom_range(0, 1)) bytes_q[at+k] = pattern_at(k);
        end
        drop_last = ($urandom_range(0, 11) == 0);
        for (k = 0; k < n; k++)
            send_byte(bytes_q[k], k == 0, (k == n - 1) && !drop_last, ROW_SCAN, none);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // a transfer on the result side happens at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: found=%0d address=%h",
                             out_ch.found, out_ch.match_address);
            end else begin
                oldest = answers_due.pop_front();
                if (oldest.found !== out_ch.found || oldest.address !== out_ch.match_address) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result mismatch: expected found=%0d address=%h, got found=%0d address=%h",
                                 oldest.found, oldest.address, out_ch.found,
                                 out_ch.match_address);
                end
            end
        end
    end

    initial begin
        int         mode;
        int         mode_left;
        int         hold_left;
        int         tick;
        logic [7:0] shape;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        shape     = 8'hA5;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                    shape     = 8'($urandom);
                end else begin
                    mode_left--;
                end
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= shape[tick % 8];
                endcase
            end
        end
    end

    initial begin
        t_dir_row       plan[$];
        t_search_answer none;
        logic [63:0]    v;
        int             phase;
        int             ranges;
        none          = '0;
        mismatches    = 0;
        bytes_scanned = 0;
        cycle_count   = 0;
        burst_left    = 0;
        eager         = 1'b0;
        long_hold_req = 1'b0;
        cur_pattern_low  = '0;
        cur_pattern_high = '0;
        cur_care         = CARE_RESET;
        cur_length       = LENGTH_RESET;
        cur_base         = '0;
        forget_range();

        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= '0;
        i_cfg_data           <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= '0;
        in_ch.first_of_range <= 1'b0;
        in_ch.last_of_range  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan = '{
            cfg_row(CFG_PATTERN_LENGTH, 64'd2),
            cfg_row(CFG_PATTERN_LOW, 64'hBBAA),
            scan_row(ROW_SCAN, 8'h11, 0, 0),
            scan_row(ROW_SCAN, 8'hAA, 0, 0),
            scan_row(ROW_SCAN_ANSWER, 8'hBB, 0, 0, t_search_answer'{1'b1, 48'h1}),
            scan_row(ROW_SCAN_QUIET, 8'hAA, 0, 0),
            cfg_row(CFG_RANGE_BASE, 64'hFFFF_FFFF_FFFF),
            cfg_row(CFG_PATTERN_LENGTH, 64'd0),
            cfg_row(CFG_PATTERN_LOW, 64'hFF),
            scan_row(ROW_SCAN, 8'h00, 1, 0),
            scan_row(ROW_SCAN, 8'h00, 0, 0),
            scan_row(ROW_SCAN_ANSWER, 8'hFF, 0, 0, t_search_answer'{1'b1, 48'h1}),
            scan_row(ROW_SCAN_ANSWER, 8'hFF, 1, 1,
                     t_search_answer'{1'b1, 48'hFFFF_FFFF_FFFF}),
            scan_row(ROW_SCAN, 8'h01, 1, 0),
            scan_row(ROW_SCAN_ANSWER, 8'h02, 0, 1, t_search_answer'{1'b0, 48'h0}),
            cfg_row(CFG_PATTERN_LENGTH, 64'd31),
            cfg_row(CFG_CARE_MASK, 64'h0),
            cfg_row(CFG_RANGE_BASE, 64'h0),
            scan_row(ROW_SCAN, 8'hFF, 1, 0),
            scan_row(ROW_SCAN, 8'hFF, 0, 0),
            scan_row(ROW_SCAN_ANSWER, 8'hFF, 0, 1, t_search_answer'{1'b0, 48'h0}),
            cfg_row(CFG_PATTERN_LENGTH, 64'd4),
            cfg_row(CFG_PATTERN_LOW, 64'h5A),
            scan_row(ROW_SCAN, 8'h5A, 1, 0),
            scan_row(ROW_SCAN, 8'h00, 0, 0),
            scan_row(ROW_SCAN, 8'h13, 0, 0),
            scan_row(ROW_SCAN, 8'h77, 0, 0),
            cfg_row(CFG_PATTERN_HIGH, 64'h80),
            cfg_row(CFG_PATTERN_LOW, 64'hFF),
            cfg_row(CFG_PATTERN_LENGTH, 64'd9),
            cfg_row(CFG_CARE_MASK, 64'h0101),
            scan_row(ROW_SCAN, 8'hFF, 1, 0),
            scan_row(ROW_SCAN, 8'h33, 0, 0),
            scan_row(ROW_SCAN, 8'h33, 0, 0),
            scan_row(ROW_SCAN, 8'h33, 0, 0),
            scan_row(ROW_SCAN, 8'h33, 0, 0),
            scan_row(ROW_SCAN, 8'h33, 0, 0),
            scan_row(ROW_SCAN, 8'h33, 0, 0),
            scan_row(ROW_SCAN, 8'h33, 0, 0),
            scan_row(ROW_SCAN, 8'h80, 0, 1)
        };

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                if (i == 0 || plan[i-1].kind != ROW_CFG) wait_idle();
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_byte(plan[i].data, plan[i].first, plan[i].last, plan[i].kind,
                          plan[i].answer);
            end
        end

        bytes_scanned = 0;
        phase         = 0;
        while (bytes_scanned < RANDOM_ITEMS) begin
            wait_idle();
            write_reg(CFG_PATTERN_LOW, pick_pattern());
            write_reg(CFG_PATTERN_HIGH, pick_pattern());
            case ($urandom_range(0, 3))
                0: v = 64'h0;
                1: v = 64'hFFFF;
                default: v = 64'($urandom_range(0, 16'hFFFF));
            endcase
            write_reg(CFG_CARE_MASK, v);
            case ($urandom_range(0, 7))
                0: v = 64'd0;
                1: v = 64'd1;
                2: v = 64'd16;
                3: v = 64'd17;
                4: v = 64'd31;
                default: v = 64'($urandom_range(1, 6));
            endcase
            write_reg(CFG_PATTERN_LENGTH, v);
            case ($urandom_range(0, 3))
                0: v = 64'h0;
                1: v = 64'hFFFF_FFFF_FFFF;
                default: v = {16'h0, 16'($urandom), $urandom};
            endcase
            write_reg(CFG_RANGE_BASE, v);

            eager  = (phase % 4 == 1) || (phase == 3);
            ranges = (phase == 3) ? 12 : $urandom_range(4, 10);
            // stall the result side while short ranges keep the input busy
            if (phase == 3) long_hold_req = 1'b1;
            repeat (ranges) begin
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), $urandom_range(0, 3) == 0,
                                  $urandom_range(0, 3) == 0, ROW_SCAN, none);
                end else begin
                    send_range(phase == 3);
                end
            end
            phase++;
        end

        eager = 1'b0;
        wait_idle();
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== masked_signature_search.f =====
src/mss_pkg.sv
src/mss_in_if.sv
src/mss_out_if.sv
src/mss_match.sv
src/masked_signature_search.sv
tb/masked_signature_search_tb.sv
